>>> hw/rtl/sslms_pkg.sv
// Package: shared widths, register indexes and controller state type for the LMS predictor.
package sslms_pkg;

  localparam int SAMPLE_W = 24;
  localparam int RESID_W  = 32;
  localparam int PRED_W   = 32;
  localparam int WEIGHT_W = 32;
  localparam int TAPCNT_W = 6;
  localparam int SHIFT_W  = 4;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int SIGN_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 1'd1;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST    = 6'd32;
  localparam logic [SHIFT_W-1:0]  SHIFT_AMOUNT_RST = 4'd9;

  // Two-bit signed sign codes
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESID_W-1:0]  resid_t;
  typedef logic signed [PRED_W-1:0]   pred_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

>>> hw/rtl/sslms_in_if.sv
// Interface: input channel carrying the current sample and its residual.
interface sslms_in_if;
  logic             valid;
  logic             ready;
  sslms_pkg::sample_t sample;
  sslms_pkg::resid_t  residual;

  modport source (output valid, output sample, output residual, input ready);
  modport sink   (input valid, input sample, input residual, output ready);
endinterface

>>> hw/rtl/sslms_out_if.sv
// Interface: output channel carrying the next-sample prediction.
interface sslms_out_if;
  logic             valid;
  logic             ready;
  sslms_pkg::pred_t prediction;

  modport source (output valid, output prediction, input ready);
  modport sink   (input valid, input prediction, output ready);
endinterface

>>> hw/rtl/sign_sign_lms_predictor.sv
// Sign-sign LMS predictor: history and weight memories with a per-tap update/MAC pipeline.
// Each accepted transaction (sample, residual) updates the used weights by
// sign(residual)*sign(history), pushes the sample into the history (newest at tap 0),
// and returns the next-sample prediction sum((w*h) >>> shift_amount), wrapping at 32 bits.
// With n = min(tap_count, MAX_TAPS) taps in use, a transaction reads its n taps one tap
// per cycle (set by the single read port of the history and weight memories) through
// two pipeline stages; the controller then sees the pipeline empty, enters the finish
// state and returns to idle with the input ready. A new sample is accepted once the
// previous one has finished; a finished prediction waits in the output register while
// the next sample is processed, and the finish cycle stalls while an earlier prediction
// is still waiting. History is a circular buffer; reset marks all entries invalid (read
// as zero), so no clearing pass is needed. Configuration is to be written only while
// idle; the block itself does not enforce this.
module sign_sign_lms_predictor #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sslms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sslms_pkg::CFG_W-1:0]           cfg_data,
  sslms_in_if.sink                              samples,
  sslms_out_if.source                           predictions
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int HW = sslms_pkg::SIGN_W + sslms_pkg::SAMPLE_W;

  // Configuration registers
  logic [sslms_pkg::TAPCNT_W-1:0] tap_count;
  logic [sslms_pkg::SHIFT_W-1:0]  shift_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= sslms_pkg::TAP_COUNT_RST;
      shift_amount <= sslms_pkg::SHIFT_AMOUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sslms_pkg::REG_TAP_COUNT:    tap_count    <= cfg_data[sslms_pkg::TAPCNT_W-1:0];
        sslms_pkg::REG_SHIFT_AMOUNT: shift_amount <= cfg_data[sslms_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Taps in use, clamped to the memory depth
  logic [CW-1:0] n_used;
  always_comb begin
    if (32'(tap_count) > 32'(MAX_TAPS)) n_used = CW'(MAX_TAPS);
    else n_used = CW'(tap_count);
  end

  // Memories and their valid bits
  logic [HW-1:0]                      hist_mem [MAX_TAPS];
  logic [sslms_pkg::WEIGHT_W-1:0]     wgt_mem  [MAX_TAPS];
  logic [MAX_TAPS-1:0]                hist_valid;
  logic [MAX_TAPS-1:0]                wgt_valid;

  // Control
  sslms_pkg::state_t  state;
  logic [AW-1:0]      head;
  logic [AW-1:0]      new_head;
  logic [CW-1:0]      iss;
  logic               iss_en;
  logic               out_free;
  logic               in_acc;
  sslms_pkg::sample_t smp_r;
  logic [sslms_pkg::SIGN_W-1:0] rsgn_r;

  // Pipeline
  logic               s1_v;
  logic               s1_first;
  logic [AW-1:0]      s1_idx;
  logic [HW-1:0]      hist_q;
  logic               hv_q;
  logic [sslms_pkg::WEIGHT_W-1:0] wgt_q;
  logic               wv_q;
  sslms_pkg::sample_t prev_smp;
  logic               s2_v;
  logic [31:0]        prod;
  logic [31:0]        acc;

  assign samples.ready = (state == sslms_pkg::ST_IDLE) && !rst;
  assign in_acc        = samples.valid && samples.ready;
  assign iss_en        = (state == sslms_pkg::ST_RUN) && (iss < n_used);
  assign out_free      = !predictions.valid || predictions.ready;
  assign new_head      = (head == '0) ? AW'(MAX_TAPS - 1) : head - AW'(1);

  // Address of old tap iss in the circular history
  logic [AW:0]   hsum;
  logic [AW-1:0] hist_addr;
  logic [AW-1:0] wgt_addr;
  always_comb begin
    hsum = {1'b0, head} + {1'b0, iss[AW-1:0]};
    if (hsum >= (AW+1)'(MAX_TAPS)) hsum = hsum - (AW+1)'(MAX_TAPS);
    hist_addr = hsum[AW-1:0];
    wgt_addr  = iss[AW-1:0];
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sslms_pkg::ST_IDLE;
      head  <= '0;
      iss   <= '0;
      predictions.valid <= 1'b0;
    end else begin
      // cleared on acceptance unless a new prediction is published in the same cycle
      if (predictions.valid && predictions.ready &&
          !(state == sslms_pkg::ST_FIN && out_free)) predictions.valid <= 1'b0;
      case (state)
        sslms_pkg::ST_IDLE: begin
          if (in_acc) begin
            iss   <= '0;
            state <= sslms_pkg::ST_RUN;
          end
        end
        sslms_pkg::ST_RUN: begin
          if (iss_en) iss <= iss + CW'(1);
          else if (!s1_v && !s2_v) state <= sslms_pkg::ST_FIN;
        end
        sslms_pkg::ST_FIN: begin
          if (out_free) begin
            head              <= new_head;
            predictions.valid <= 1'b1;
            state             <= sslms_pkg::ST_IDLE;
          end
        end
        default: state <= sslms_pkg::ST_IDLE;
      endcase
    end
  end

  // Latched transaction fields and result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= samples.sample;
      if (samples.residual == '0) rsgn_r <= sslms_pkg::SIGN_ZERO;
      else if (samples.residual[sslms_pkg::RESID_W-1]) rsgn_r <= sslms_pkg::SIGN_NEG;
      else rsgn_r <= sslms_pkg::SIGN_POS;
    end
    if (state == sslms_pkg::ST_FIN && out_free) predictions.prediction <= acc;
  end

  // History memory: read one tap per cycle, push the new sample on finish
  always_ff @(posedge clk) begin
    hist_q <= hist_mem[hist_addr];
    if (state == sslms_pkg::ST_FIN && out_free) begin
      if (smp_r == '0) hist_mem[new_head] <= {sslms_pkg::SIGN_ZERO, smp_r};
      else if (smp_r[sslms_pkg::SAMPLE_W-1]) hist_mem[new_head] <= {sslms_pkg::SIGN_NEG, smp_r};
      else hist_mem[new_head] <= {sslms_pkg::SIGN_POS, smp_r};
    end
  end

  // Weight memory: read one tap per cycle, write back the updated weight
  logic [sslms_pkg::WEIGHT_W-1:0] w_new;
  always_ff @(posedge clk) begin
    wgt_q <= wgt_mem[wgt_addr];
    if (s1_v) wgt_mem[s1_idx] <= w_new;
  end

  // Valid bits; an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      wgt_valid  <= '0;
      hv_q       <= 1'b0;
      wv_q       <= 1'b0;
    end else begin
      hv_q <= hist_valid[hist_addr];
      wv_q <= wgt_valid[wgt_addr];
      if (state == sslms_pkg::ST_FIN && out_free) hist_valid[new_head] <= 1'b1;
      if (s1_v) wgt_valid[s1_idx] <= 1'b1;
    end
  end

  // Stage 1: weight update and multiply
  logic [sslms_pkg::SIGN_W-1:0] old_sign;
  sslms_pkg::sample_t           old_smp;
  sslms_pkg::sample_t           new_smp;
  logic [sslms_pkg::WEIGHT_W-1:0] w_cur;
  logic [31:0]                  delta;
  always_comb begin
    old_sign = hv_q ? hist_q[HW-1 -: sslms_pkg::SIGN_W] : sslms_pkg::SIGN_ZERO;
    old_smp  = hv_q ? hist_q[sslms_pkg::SAMPLE_W-1:0] : '0;
    w_cur    = wv_q ? wgt_q : '0;
    if (old_sign == sslms_pkg::SIGN_ZERO || rsgn_r == sslms_pkg::SIGN_ZERO) delta = '0;
    else if (old_sign == rsgn_r) delta = 32'd1;
    else delta = '1;
    w_new   = w_cur + delta;
    new_smp = s1_first ? smp_r : prev_smp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= iss_en;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= wgt_addr;
    s1_first <= (iss == '0);
    if (s1_v) begin
      prev_smp <= old_smp;
      prod     <= w_new * {{(32 - sslms_pkg::SAMPLE_W){new_smp[sslms_pkg::SAMPLE_W-1]}},
                           new_smp};
    end
  end

  // Stage 2: shift and accumulate
  always_ff @(posedge clk) begin
    if (in_acc) acc <= '0;
    else if (s2_v) acc <= acc + 32'($signed(prod) >>> shift_amount);
  end

  // Checks
  a_fin_drained: assert property (@(posedge clk) disable iff (rst)
    (state == sslms_pkg::ST_FIN) |-> (!s1_v && !s2_v))
    else $error("finish reached with taps still in flight");

  a_s2_follows_s1: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> $past(s1_v))
    else $error("accumulate without a preceding multiply");

  a_fin_emits: assert property (@(posedge clk) disable iff (rst)
    (state == sslms_pkg::ST_FIN && out_free) |=>
      (predictions.valid && head == $past(new_head) && state == sslms_pkg::ST_IDLE))
    else $error("finish did not publish a prediction");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == sslms_pkg::ST_RUN && acc == '0 && iss == '0))
    else $error("accepted transaction did not start a clean run");

endmodule

>>> bench/sign_sign_lms_predictor_tb.sv
// Testbench for the sign-sign LMS predictor: directed and random samples checked by a predictor.
`timescale 1ns / 1ps

module sign_sign_lms_predictor_tb;

  localparam int MAX_TAPS   = 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [sslms_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sslms_pkg::CFG_W-1:0]     cfg_data;

  sslms_in_if  samples_if ();
  sslms_out_if predictions_if ();

  sign_sign_lms_predictor #(.MAX_TAPS(MAX_TAPS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .samples     (samples_if),
    .predictions (predictions_if)
  );

  // Predictor state and register copies
  sslms_pkg::sample_t hist_smp [MAX_TAPS] = '{default: '0};
  int                 hist_sgn [MAX_TAPS] = '{default: 0};
  logic [31:0]        tap_w    [MAX_TAPS] = '{default: '0};
  logic [sslms_pkg::TAPCNT_W-1:0] taps_cfg  = sslms_pkg::TAP_COUNT_RST;
  logic [sslms_pkg::SHIFT_W-1:0]  shift_cfg = sslms_pkg::SHIFT_AMOUNT_RST;
  sslms_pkg::pred_t   last_prediction = '0;

  sslms_pkg::pred_t expected_predictions [$];
  int    errors = 0;
  int    walk = 0;
  bit    src_idle = 1'b1;
  bit    sink_idle = 1'b1;
  int    sink_hold = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Weight update, history shift and next-sample prediction for one transaction
  function automatic sslms_pkg::pred_t predict_next(input sslms_pkg::sample_t s,
                                                    input sslms_pkg::resid_t r);
    int unsigned       n;
    int                rs;
    logic [31:0]       acc;
    logic [31:0]       prod;
    logic [31:0]       ext;
    logic signed [31:0] part;
    n  = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
    rs = (r == 0) ? 0 : ((r < 0) ? -1 : 1);
    for (int i = 0; i < n; i++) tap_w[i] = tap_w[i] + 32'(rs * hist_sgn[i]);
    // whole history shifts regardless of tap count
    for (int i = MAX_TAPS - 1; i > 0; i--) begin
      hist_smp[i] = hist_smp[i-1];
      hist_sgn[i] = hist_sgn[i-1];
    end
    hist_smp[0] = s;
    hist_sgn[0] = (s > 0) ? 1 : ((s < 0) ? -1 : 0);
    acc = '0;
    for (int i = 0; i < n; i++) begin
      ext  = {{(32-sslms_pkg::SAMPLE_W){hist_smp[i][sslms_pkg::SAMPLE_W-1]}}, hist_smp[i]};
      prod = tap_w[i] * ext;
      part = $signed(prod) >>> shift_cfg;
      acc  = acc + part;
    end
    last_prediction = acc;
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input sslms_pkg::pred_t got,
                                 input sslms_pkg::pred_t want);
    $display("%0t MISMATCH %s: got %0d (0x%08h) expected %0d (0x%08h)",
             $realtime, what, got, got, want, want);
    errors++;
  endtask

  // Sender: one transaction, entered and left at a falling edge
  task automatic send_item(input sslms_pkg::sample_t s, input sslms_pkg::resid_t r);
    int gap;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid    <= 1'b1;
    samples_if.sample   <= s;
    samples_if.residual <= r;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    expected_predictions.push_back(predict_next(s, r));
    @(negedge clk);
  endtask

  // Audio-like: random walk with residual against the running prediction; else noise
  task automatic send_random_item(input bit audio_like);
    sslms_pkg::sample_t s;
    sslms_pkg::resid_t  r;
    if (audio_like) begin
      walk = walk + int'($urandom_range(0, 4000)) - 2000;
      if ($urandom_range(0, 31) == 0) walk = int'(sslms_pkg::sample_t'($urandom));
      if (walk > 8388607) walk = 8388607;
      if (walk < -8388608) walk = -8388608;
      s = sslms_pkg::sample_t'(walk);
      r = sslms_pkg::resid_t'(int'(s) - int'(last_prediction));
    end else begin
      s = sslms_pkg::sample_t'($urandom);
      case ($urandom_range(0, 3))
        0:       r = '0;
        1:       r = sslms_pkg::resid_t'(int'($urandom_range(0, 64)) - 32);
        default: r = sslms_pkg::resid_t'($urandom);
      endcase
    end
    send_item(s, r);
  endtask

  // Wait until every prediction is back and the block is idle
  task automatic drain();
    samples_if.valid <= 1'b0;
    while (expected_predictions.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input logic [sslms_pkg::CFG_W-1:0] taps,
                           input logic [sslms_pkg::CFG_W-1:0] shift_data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= sslms_pkg::REG_TAP_COUNT;
    cfg_data  <= taps;
    @(negedge clk);
    cfg_index <= sslms_pkg::REG_SHIFT_AMOUNT;
    cfg_data  <= shift_data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    taps_cfg  = taps[sslms_pkg::TAPCNT_W-1:0];
    shift_cfg = shift_data[sslms_pkg::SHIFT_W-1:0];
  endtask

  // Default registers after reset, extreme samples and residuals
  task automatic test_reset_defaults();
    send_item(24'sh7FFFFF, 32'sh7FFFFFFF);
    send_item(24'sh800000, 32'sh80000000);
    send_item(24'sh000000, 32'sh00000000);
    send_item(24'sh000001, 32'sh00000001);
    send_item(24'shFFFFFF, 32'shFFFFFFFF);
    send_item(24'sh7FFFFF, 32'sh80000000);
    send_item(24'sh800000, 32'sh7FFFFFFF);
    send_item(24'sh123456, 32'sh00000001);
    send_item(24'shEDCBA9, 32'shFFFFFFFF);
    send_item(24'sh7FFFFF, 32'sh00000000);
  endtask

  // Zero taps, one tap, tap counts past the maximum, shift extremes
  task automatic test_tap_extremes();
    configure(6'd0, 6'd9);
    repeat (3) send_random_item(1'b0);
    configure(6'd1, 6'h38);    // upper data bits set, shift of 8
    repeat (3) send_random_item(1'b0);
    configure(6'd33, 6'd0);
    repeat (3) send_random_item(1'b0);
    configure(6'd63, 6'd15);
    repeat (3) send_random_item(1'b0);
    configure(6'd32, 6'h3F);
    repeat (3) send_random_item(1'b0);
  endtask

  // Phases with random settings, mostly audio-like sample streams
  task automatic test_random_configs();
    logic [sslms_pkg::CFG_W-1:0]   taps;
    logic [sslms_pkg::SHIFT_W-1:0] sh;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0:       taps = 6'd0;
        1:       taps = 6'd32;
        2:       taps = 6'($urandom_range(33, 63));
        default: taps = 6'($urandom_range(1, 16));
      endcase
      sh = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(8, 9)) : 4'($urandom_range(0, 15));
      configure(taps, {2'($urandom), sh});
      src_idle  = (phase % 4) != 2;
      sink_idle = (phase % 4) != 3;
      repeat (48) send_random_item($urandom_range(0, 9) < 7);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Long receiver stall while the sender keeps offering samples
  task automatic test_output_backpressure();
    configure(6'd8, 6'd9);
    src_idle  = 1'b0;
    sink_hold = HOLD_CYCLES;
    repeat (12) send_random_item(1'b1);
    src_idle  = 1'b1;
  endtask

  // Sender pauses until every prediction is back, then resumes
  task automatic test_drain_pause();
    configure(6'd32, 6'd8);
    repeat (15) send_random_item(1'b1);
    drain();
    repeat (15) send_random_item(1'b1);
  endtask

  // Receiver: random ready gaps, plus a long hold when requested
  initial begin : sink_proc
    int gap;
    predictions_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        predictions_if.ready <= 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      gap = sink_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        predictions_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      predictions_if.ready <= 1'b1;
      @(posedge clk);
      while (!predictions_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each accepted prediction with the oldest expectation
  always @(posedge clk) begin : check_predictions
    sslms_pkg::pred_t want;
    if (!rst && predictions_if.valid && predictions_if.ready) begin
      if (expected_predictions.size() == 0) begin
        report_mismatch("prediction with none outstanding", predictions_if.prediction, '0);
      end else begin
        want = expected_predictions.pop_front();
        if (predictions_if.prediction !== want)
          report_mismatch("prediction", predictions_if.prediction, want);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (samples_if.valid && samples_if.ready) ||
        (predictions_if.valid && predictions_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout with %0d predictions outstanding", expected_predictions.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : run_tests
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = sslms_pkg::REG_TAP_COUNT;
    cfg_data            = '0;
    samples_if.valid    = 1'b0;
    samples_if.sample   = '0;
    samples_if.residual = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_tap_extremes();
    test_random_configs();
    test_output_backpressure();
    test_drain_pause();

    drain();
    repeat (40) @(negedge clk);
    if (errors == 0 && expected_predictions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sslms_pkg.sv
hw/rtl/sslms_in_if.sv
hw/rtl/sslms_out_if.sv
hw/rtl/sign_sign_lms_predictor.sv
bench/sign_sign_lms_predictor_tb.sv
